FILE: rtl/c_comment_strip_space_collapse_macros.svh
// Assertion macros shared by the comment stripper RTL.
// Included by the top level; depends on nothing else.
`ifndef C_COMMENT_STRIP_SPACE_COLLAPSE_MACROS_SVH
`define C_COMMENT_STRIP_SPACE_COLLAPSE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ccs_pkg.sv
// Package for the comment stripper: byte classes, scan states, character codes,
// the transition table and the result struct. No dependencies.
`default_nettype none

package ccs_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_SLASH  = 3'd1;
    localparam logic [2:0] CLS_STAR   = 3'd2;
    localparam logic [2:0] CLS_BSLASH = 3'd3;
    localparam logic [2:0] CLS_SQUOTE = 3'd4;
    localparam logic [2:0] CLS_DQUOTE = 3'd5;
    localparam logic [2:0] CLS_NL     = 3'd6;
    localparam logic [2:0] CLS_OTHER  = 3'd7;

    localparam logic [3:0] ST_CODE       = 4'd0;
    localparam logic [3:0] ST_SLASH      = 4'd1;
    localparam logic [3:0] ST_LINE       = 4'd2;
    localparam logic [3:0] ST_BLOCK      = 4'd3;
    localparam logic [3:0] ST_LINE_ESC   = 4'd4;
    localparam logic [3:0] ST_BLOCK_STAR = 4'd5;
    localparam logic [3:0] ST_STR        = 4'd6;
    localparam logic [3:0] ST_STR_ESC    = 4'd7;
    localparam logic [3:0] ST_CHR        = 4'd8;
    localparam logic [3:0] ST_CHR_ESC    = 4'd9;

    localparam logic [3:0] NEXT_TAB [0:9][0:7] = '{
        '{4'd0, 4'd1, 4'd0, 4'd0, 4'd8, 4'd6, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd0, 4'd8, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd2, 4'd4, 4'd2, 4'd2, 4'd0, 4'd2},
        '{4'd0, 4'd3, 4'd5, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
        '{4'd0, 4'd2, 4'd2, 4'd4, 4'd2, 4'd2, 4'd4, 4'd2},
        '{4'd0, 4'd0, 4'd5, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
        '{4'd0, 4'd6, 4'd6, 4'd7, 4'd6, 4'd0, 4'd6, 4'd6},
        '{4'd0, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6},
        '{4'd0, 4'd8, 4'd8, 4'd9, 4'd0, 4'd8, 4'd8, 4'd8},
        '{4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8}
    };

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } result_t;

    function automatic logic [2:0] byte_class(input logic [7:0] b);
        logic [2:0] cls;
        begin
            case (b)
                CH_SLASH:  cls = CLS_SLASH;
                CH_STAR:   cls = CLS_STAR;
                CH_BSLASH: cls = CLS_BSLASH;
                CH_SQUOTE: cls = CLS_SQUOTE;
                CH_DQUOTE: cls = CLS_DQUOTE;
                CH_NL:     cls = CLS_NL;
                default:   cls = CLS_OTHER;
            endcase
            return cls;
        end
    endfunction

    function automatic logic [3:0] next_state(input logic [3:0] cur, input logic [2:0] cls);
        logic [3:0] row;
        begin
            row = (cur > ST_CHR_ESC) ? ST_CODE : cur;
            return NEXT_TAB[row][cls];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ccs_scan.sv
// Scanner: classifies each request byte, steps the state table and forms up
// to two result bytes. Depends on ccs_pkg.
`default_nettype none

module ccs_scan (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      in_byte,
    output ccs_pkg::result_t     res
);

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       slash_reg;
    logic       slash_next;
    logic       space_reg;
    logic       space_next;

    logic [2:0] cls;
    logic       blank;
    logic       emit_slash;
    logic       main_valid;
    logic [7:0] main_byte;

    always_comb
    begin
        cls        = ccs_pkg::byte_class(in_byte);
        state_next = ccs_pkg::next_state(state_reg, cls);
        blank      = in_byte inside {ccs_pkg::CH_SPACE, ccs_pkg::CH_TAB, ccs_pkg::CH_CR,
                                     ccs_pkg::CH_NL, ccs_pkg::CH_BSLASH};
        emit_slash = slash_reg && (state_next != ccs_pkg::ST_LINE)
                               && (state_next != ccs_pkg::ST_BLOCK);
        slash_next = (state_next == ccs_pkg::ST_SLASH);
        space_next = space_reg;
        main_valid = 1'b0;
        main_byte  = in_byte;

        if (state_next == ccs_pkg::ST_CODE)
        begin
            if (!slash_reg && cls == ccs_pkg::CLS_SLASH)
            begin
                main_valid = 1'b0;
            end
            else if (blank)
            begin
                if (!space_reg)
                begin
                    main_valid = 1'b1;
                    main_byte  = ccs_pkg::CH_SPACE;
                    space_next = 1'b1;
                end
            end
            else
            begin
                main_valid = 1'b1;
                space_next = 1'b0;
            end
        end
        else if (state_next >= ccs_pkg::ST_STR)
        begin
            main_valid = 1'b1;
        end

        res.count = {1'b0, emit_slash} + {1'b0, main_valid};
        res.byte0 = emit_slash ? ccs_pkg::CH_SLASH : main_byte;
        res.byte1 = main_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccs_pkg::ST_CODE;
            slash_reg <= 1'b0;
            space_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            slash_reg <= slash_next;
            space_reg <= space_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ccs_outq.sv
// Three-entry output queue: takes up to two result bytes a cycle, drives the
// master stream from its head entry. Depends on ccs_pkg.
`default_nettype none

module ccs_outq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ccs_pkg::result_t res,
    output logic                 room,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);

    logic [8:0] q_reg [0:2];
    logic [8:0] q_next [0:2];
    logic [8:0] sh [0:2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    logic [1:0] base;
    logic [1:0] n;
    logic [8:0] item0;
    logic [8:0] item1;

    always_comb
    begin
        pop   = (count_reg != 2'd0) && m_tready;
        n     = push ? res.count : 2'd0;
        base  = count_reg - {1'b0, pop};
        item0 = {(res.count == 2'd1), res.byte0};
        item1 = {1'b1, res.byte1};

        sh[0] = pop ? q_reg[1] : q_reg[0];
        sh[1] = pop ? q_reg[2] : q_reg[1];
        sh[2] = q_reg[2];

        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) == base && n != 2'd0)
                q_next[i] = item0;
            else if (2'(i) == base + 2'd1 && n == 2'd2)
                q_next[i] = item1;
            else
                q_next[i] = sh[i];
        end

        count_next = base + n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            q_reg[i] <= q_next[i];
    end

    assign room     = (count_reg <= 2'd1);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = q_reg[0][7:0];
    assign m_tlast  = q_reg[0][8];

endmodule

`default_nettype wire

FILE: rtl/c_comment_strip_space_collapse.sv
// C comment stripper with whitespace collapsing. One source byte per request
// in, up to two cleaned bytes per request out; a request whose byte follows a
// held slash may give two output bytes, tlast marks the last byte of each request's
// output, and a byte that disappears (inside a comment, or an extra blank) gives
// none. The block takes a byte in every cycle while its three-entry output queue
// holds at most one byte; a byte that yields two results drops s_tready until the
// queue drains back to one byte. Results are registered in the output queue before
// they reach the master side. Uses ccs_pkg, ccs_scan, ccs_outq and the macros header.
`default_nettype none

`include "c_comment_strip_space_collapse_macros.svh"

module c_comment_strip_space_collapse (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // last
);

    ccs_pkg::result_t res;
    logic             accept;
    logic             room;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    ccs_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .res     (res)
    );

    ccs_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `CCS_ASSERT_NOW(a_empty_accepts, clk, rst_n, !m_tvalid, s_tready, "empty queue refuses")
    `CCS_ASSERT_NEXT(a_result_shows, clk, rst_n, accept && res.count != 2'd0, m_tvalid, "lost")
    `CCS_ASSERT_NOW(a_pair_blocks, clk, rst_n, m_tvalid && !m_tlast, !s_tready, "split pair open")

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Testbench for c_comment_strip_space_collapse: random C-like byte streams with
// random gaps and stalls, checked against a cycle-free model of the scanner.
// Depends on ccs_pkg and the RTL top level only.
`default_nettype none

localparam logic [3:0] SCAN_NEXT [0:9][0:7] = '{
    '{4'd0, 4'd1, 4'd0, 4'd0, 4'd8, 4'd6, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd0, 4'd8, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd2, 4'd4, 4'd2, 4'd2, 4'd0, 4'd2},
    '{4'd0, 4'd3, 4'd5, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
    '{4'd0, 4'd2, 4'd2, 4'd4, 4'd2, 4'd2, 4'd4, 4'd2},
    '{4'd0, 4'd0, 4'd5, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
    '{4'd0, 4'd6, 4'd6, 4'd7, 4'd6, 4'd0, 4'd6, 4'd6},
    '{4'd0, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6},
    '{4'd0, 4'd8, 4'd8, 4'd9, 4'd0, 4'd8, 4'd8, 4'd8},
    '{4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8}
};

typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
} cleaned_byte_t;

class strip_scoreboard;
    logic [3:0]    scan = ccs_pkg::ST_CODE;
    bit            slash_held = 1'b0;
    bit            blank_sent = 1'b0;
    cleaned_byte_t expected_bytes [$];
    int unsigned   errors = 0;

    function logic [2:0] classify(logic [7:0] b);
        case (b)
            ccs_pkg::CH_SLASH:  return ccs_pkg::CLS_SLASH;
            ccs_pkg::CH_STAR:   return ccs_pkg::CLS_STAR;
            ccs_pkg::CH_BSLASH: return ccs_pkg::CLS_BSLASH;
            ccs_pkg::CH_SQUOTE: return ccs_pkg::CLS_SQUOTE;
            ccs_pkg::CH_DQUOTE: return ccs_pkg::CLS_DQUOTE;
            ccs_pkg::CH_NL:     return ccs_pkg::CLS_NL;
            default:            return ccs_pkg::CLS_OTHER;
        endcase
    endfunction

    function bit is_blank(logic [7:0] b);
        return b == ccs_pkg::CH_SPACE || b == ccs_pkg::CH_TAB || b == ccs_pkg::CH_CR
            || b == ccs_pkg::CH_NL || b == ccs_pkg::CH_BSLASH;
    endfunction

    function void note_request(logic [7:0] b);
        logic [2:0]    cls;
        logic [3:0]    row;
        logic [3:0]    nxt;
        logic [7:0]    outs [$];
        cleaned_byte_t item;
        cls = classify(b);
        row = (scan > ccs_pkg::ST_CHR_ESC) ? ccs_pkg::ST_CODE : scan;
        nxt = SCAN_NEXT[row][cls];
        // release a held slash unless it opened a comment
        if (slash_held && nxt != ccs_pkg::ST_LINE && nxt != ccs_pkg::ST_BLOCK)
            outs.push_back(ccs_pkg::CH_SLASH);
        if (nxt == ccs_pkg::ST_CODE)
        begin
            // a bare slash landing in code closes a block comment: drop it
            if (slash_held || cls != ccs_pkg::CLS_SLASH)
            begin
                if (is_blank(b))
                begin
                    if (!blank_sent)
                    begin
                        outs.push_back(ccs_pkg::CH_SPACE);
                        blank_sent = 1'b1;
                    end
                end
                else
                begin
                    blank_sent = 1'b0;
                    outs.push_back(b);
                end
            end
        end
        else if (nxt >= ccs_pkg::ST_STR)
        begin
            outs.push_back(b);
        end
        slash_held = (nxt == ccs_pkg::ST_SLASH);
        scan = nxt;
        foreach (outs[k])
        begin
            item.out_byte = outs[k];
            item.last = (k == outs.size() - 1);
            expected_bytes.push_back(item);
        end
    endfunction

    function void check_result(logic [7:0] out_byte, logic last, time stamp);
        cleaned_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            errors++;
            if (errors < 50)
                $display("%0t: unexpected result, expected none, actual out_byte %h last %b",
                         stamp, out_byte, last);
            return;
        end
        want = expected_bytes.pop_front();
        if (out_byte !== want.out_byte)
        begin
            errors++;
            if (errors < 50)
                $display("%0t: out_byte mismatch, expected %h, actual %h",
                         stamp, want.out_byte, out_byte);
        end
        if (last !== want.last)
        begin
            errors++;
            if (errors < 50)
                $display("%0t: last mismatch, expected %b, actual %b", stamp, want.last, last);
        end
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int ITEM_TARGET  = 1050;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [7:0] BLANKS [0:4] = '{
        ccs_pkg::CH_SPACE, ccs_pkg::CH_TAB, ccs_pkg::CH_CR, ccs_pkg::CH_NL, ccs_pkg::CH_BSLASH
    };
    localparam logic [7:0] SPECIALS [0:7] = '{
        ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR, ccs_pkg::CH_BSLASH, ccs_pkg::CH_SQUOTE,
        ccs_pkg::CH_DQUOTE, ccs_pkg::CH_NL, ccs_pkg::CH_CR, ccs_pkg::CH_TAB
    };
    localparam logic [7:0] OPENING [0:26] = '{
        8'h00, 8'hFF, ccs_pkg::CH_SPACE, ccs_pkg::CH_TAB,
        ccs_pkg::CH_SLASH, ccs_pkg::CH_DQUOTE, ccs_pkg::CH_BSLASH, ccs_pkg::CH_DQUOTE,
        ccs_pkg::CH_DQUOTE,
        ccs_pkg::CH_SPACE, ccs_pkg::CH_SLASH, ccs_pkg::CH_SPACE,
        ccs_pkg::CH_SLASH, ccs_pkg::CH_SQUOTE, ccs_pkg::CH_BSLASH, ccs_pkg::CH_SQUOTE,
        ccs_pkg::CH_SQUOTE,
        ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR, ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH,
        ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, ccs_pkg::CH_BSLASH, ccs_pkg::CH_NL,
        ccs_pkg::CH_NL, ccs_pkg::CH_CR
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;   // last

    strip_scoreboard sb = new;
    logic [7:0]      source_bytes [$];
    bit              calm = 1'b0;
    int unsigned     idle_cycles = 0;

    c_comment_strip_space_collapse u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned pick_gap(int unsigned short_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < short_pct)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_text();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 72)
            return 8'($urandom_range(8'h20, 8'h7E));
        if (r < 90)
            return SPECIALS[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_fragment();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 99);
        n = $urandom_range(0, 6);
        if (kind < 16)
        begin
            repeat (n + 1) source_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
        else if (kind < 28)
        begin
            repeat (n % 4 + 1) source_bytes.push_back(BLANKS[$urandom_range(0, 4)]);
        end
        else if (kind < 42)
        begin
            source_bytes.push_back(ccs_pkg::CH_DQUOTE);
            repeat (n)
            begin
                if ($urandom_range(0, 5) == 0)
                    source_bytes.push_back(ccs_pkg::CH_BSLASH);
                source_bytes.push_back(pick_text());
            end
            source_bytes.push_back(ccs_pkg::CH_DQUOTE);
        end
        else if (kind < 52)
        begin
            source_bytes.push_back(ccs_pkg::CH_SQUOTE);
            if ($urandom_range(0, 2) == 0)
                source_bytes.push_back(ccs_pkg::CH_BSLASH);
            source_bytes.push_back(pick_text());
            source_bytes.push_back(ccs_pkg::CH_SQUOTE);
        end
        else if (kind < 64)
        begin
            source_bytes.push_back(ccs_pkg::CH_SLASH);
            source_bytes.push_back(ccs_pkg::CH_SLASH);
            repeat (n)
            begin
                // line continuation inside the comment
                if ($urandom_range(0, 5) == 0)
                    source_bytes.push_back(ccs_pkg::CH_BSLASH);
                source_bytes.push_back(pick_text());
            end
            source_bytes.push_back(ccs_pkg::CH_NL);
        end
        else if (kind < 78)
        begin
            source_bytes.push_back(ccs_pkg::CH_SLASH);
            source_bytes.push_back(ccs_pkg::CH_STAR);
            repeat (n)
                source_bytes.push_back(($urandom_range(0, 3) == 0) ? ccs_pkg::CH_STAR
                                                                   : pick_text());
            repeat ($urandom_range(1, 3)) source_bytes.push_back(ccs_pkg::CH_STAR);
            source_bytes.push_back(ccs_pkg::CH_SLASH);
        end
        else if (kind < 90)
        begin
            source_bytes.push_back(ccs_pkg::CH_SLASH);
            source_bytes.push_back(($urandom_range(0, 1) == 0) ? SPECIALS[$urandom_range(2, 7)]
                                                               : pick_text());
        end
        else
        begin
            repeat (n % 4 + 1) source_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_request(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap(55);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        foreach (OPENING[i])
            source_bytes.push_back(OPENING[i]);
        while (source_bytes.size() < ITEM_TARGET)
            add_fragment();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (source_bytes[i])
        begin
            calm = ((i / 150) % 4) == 3;
            send_request(source_bytes[i]);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = pick_gap(60);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // sample handshakes mid-cycle; the request is taken at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, $time);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, sb.pending());
                $display("TEST FAILED");
                $finish;
            end
        end
    end
endmodule

`default_nettype wire

FILE: c_comment_strip_space_collapse.f
+incdir+rtl
rtl/ccs_pkg.sv
rtl/ccs_scan.sv
rtl/ccs_outq.sv
rtl/c_comment_strip_space_collapse.sv
dv/testbench.sv
